[rtl/lsc_pkg.sv]
`default_nettype none
package lsc_pkg;

  localparam int unsigned MAX_SPACING_DEF  = 16;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned SPACING_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPACING    = 1'b0,
    REG_NOISE_SEED = 1'b1
  } reg_idx_e;

  localparam logic [31:0] SEED_RESET  = 32'd2463534242;
  localparam int          THR_Q       = 952641;
  localparam int          CEIL_Q      = 985661;
  localparam int          SLEW_K_Q    = 1466540;
  localparam int          NOISE_K_Q32 = 326417514;
  localparam logic [40:0] CEIL_Q40    = 41'd1033540930109;

  localparam int unsigned MUL_AW = 34;
  localparam int unsigned MUL_BW = 30;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned K_W    = 29;

  typedef struct packed {
    logic load_in;
    logic mul_k;
    logic load_k;
    logic mul_blend;
    logic neg_side;
    logic blend_b_x;
    logic wr_held_blend;
    logic wr_held_ceil;
    logic wr_x_blend;
    logic pos_upd;
    logic neg_upd;
    logic shift;
    logic scan;
    logic start_mag;
    logic wr_held_div;
    logic mul_slew;
    logic start_pc;
    logic finish;
  } lsc_cmd_t;

  typedef struct packed {
    logic pos_flag;
    logic neg_flag;
    logic x_gt_thr;
    logic x_lt_nthr;
    logic x_lt_held;
    logic x_gt_held;
    logic scan_last;
    logic div_busy;
    logic out_free;
  } lsc_stat_t;

endpackage
`default_nettype wire

[rtl/lsc_if.sv]
`default_nettype none
interface lsc_in_if #(
  parameter int unsigned SAMPLE_WIDTH = lsc_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;
  modport source (output valid, output in_sample, input ready);
  modport sink (input valid, input in_sample, output ready);
endinterface

interface lsc_out_if #(
  parameter int unsigned SAMPLE_WIDTH = lsc_pkg::SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  modport source (output valid, output out_sample, input ready);
  modport sink (input valid, input out_sample, output ready);
endinterface
`default_nettype wire

[rtl/lsc_div.sv]
`default_nettype none
module lsc_div #(
  parameter int unsigned NW = 41,
  parameter int unsigned DW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          busy_o,
  output logic [NW-1:0] quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic [DW:0]     rem_sh;
  logic [DW:0]     diff;
  logic            ge;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign ge     = ~diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNTW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/lsc_datapath.sv]
`default_nettype none
module lsc_datapath #(
  parameter int unsigned MAX_SPACING  = lsc_pkg::MAX_SPACING_DEF,
  parameter int unsigned SAMPLE_WIDTH = lsc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_i,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  lsc_pkg::lsc_cmd_t                   cmd_i,
  output lsc_pkg::lsc_stat_t                  stat_o
);
  import lsc_pkg::*;

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned SLW  = SW + 1;
  localparam int unsigned SPW  = $clog2(MAX_SPACING + 1);
  localparam int unsigned WD   = 2 * MAX_SPACING + 1;
  localparam int unsigned IW   = $clog2(WD);
  localparam int unsigned DD   = MAX_SPACING + 1;
  localparam int unsigned DIW  = $clog2(DD);
  localparam int unsigned SUMW = SW + $clog2(MAX_SPACING + 1) + 1;
  localparam int unsigned DW   = (SW + 2 > 22) ? SW + 2 : 22;
  localparam int unsigned DIVN = (SUMW > 41) ? SUMW : 41;
  localparam int unsigned CW   = ((SW > 21) ? SW : 21) + 1;

  logic [SPACING_W-1:0]    spacing_q;
  logic [31:0]             noise_q;
  logic signed [SW-1:0]    x_q;
  logic signed [SW-1:0]    held_q;
  logic signed [SW-1:0]    y_q;
  logic                    pos_q;
  logic                    neg_q;
  logic [K_W-1:0]          k_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SLW-1:0]          slew_q [WD];
  logic signed [SW-1:0]    dly_q [DD];
  logic [IW-1:0]           idx_q;
  logic [SLW-1:0]          max_q;
  logic signed [SUMW-1:0]  sum_q;
  logic signed [SW-1:0]    out_q;
  logic                    out_valid_q;

  logic [SPW-1:0]           s_w;
  logic [IW-1:0]            two_s_w;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_w;
  logic signed [63:0]       a64;
  logic signed [63:0]       b64;
  logic signed [63:0]       diff64;
  logic signed [63:0]       res64;
  logic signed [SW-1:0]     blend_res;
  logic signed [SW-1:0]     ceil_res;
  logic signed [SLW-1:0]    dif_w;
  logic [SLW-1:0]           slew_mag;
  logic [SUMW-1:0]          sum_abs;
  logic signed [63:0]       dv64;
  logic [DW-1:0]            dvs_w;
  logic                     div_start;
  logic [DIVN-1:0]          div_num;
  logic [DW-1:0]            div_den;
  logic                     div_busy;
  logic [DIVN-1:0]          div_q;
  logic signed [SW-1:0]     held_div;
  logic signed [CW-1:0]     pc_w;
  logic signed [CW-1:0]     y_ext;
  logic signed [SW-1:0]     clip_res;
  logic [31:0]              nx1;
  logic [31:0]              nx2;
  logic [31:0]              nx3;

  always_comb begin
    if (spacing_q == '0) begin
      s_w = SPW'(1);
    end else if (32'(spacing_q) > MAX_SPACING) begin
      s_w = SPW'(MAX_SPACING);
    end else begin
      s_w = SPW'(spacing_q);
    end
  end
  assign two_s_w = IW'({s_w, 1'b0});

  assign a64    = cmd_i.neg_side ? -64'sd952641 : 64'sd952641;
  assign b64    = cmd_i.blend_b_x ? 64'(x_q) : 64'(held_q);
  assign diff64 = b64 - a64;

  always_comb begin
    if (cmd_i.mul_k) begin
      mul_a = $signed({2'b00, noise_q});
      mul_b = MUL_BW'(NOISE_K_Q32);
    end else if (cmd_i.mul_slew) begin
      mul_a = $signed(MUL_AW'(max_q));
      mul_b = MUL_BW'(SLEW_K_Q);
    end else begin
      mul_a = diff64[MUL_AW-1:0];
      mul_b = $signed({1'b0, k_q});
    end
  end
  assign prod_w = mul_a * mul_b;

  assign res64     = a64 + ((prod_q + 64'sd2147483648) >>> 32);
  assign blend_res = res64[SW-1:0];
  assign ceil_res  = cmd_i.neg_side ? SW'(-CEIL_Q) : SW'(CEIL_Q);

  assign dif_w    = SLW'(held_q) - SLW'(x_q);
  assign slew_mag = dif_w[SLW-1] ? SLW'(-dif_w) : SLW'(dif_w);

  assign sum_abs = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
  assign dv64    = 64'sd1048576 + ((prod_q + 64'sd524288) >>> 20);
  assign dvs_w   = dv64[DW-1:0];

  assign div_start = cmd_i.start_mag | cmd_i.start_pc;
  always_comb begin
    if (cmd_i.start_pc) begin
      div_num = DIVN'(CEIL_Q40) + DIVN'(dvs_w >> 1);
      div_den = dvs_w;
    end else begin
      div_num = DIVN'(sum_abs) + DIVN'(s_w >> 1);
      div_den = DW'(s_w);
    end
  end

  lsc_div #(
    .NW (DIVN),
    .DW (DW)
  ) u_lsc_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  always_comb begin
    if (sum_q[SUMW-1]) begin
      if (div_q >= (DIVN'(1) << (SW - 1))) begin
        held_div = {1'b1, {(SW-1){1'b0}}};
      end else begin
        held_div = -$signed(div_q[SW-1:0]);
      end
    end else begin
      if (div_q >= (DIVN'(1) << (SW - 1))) begin
        held_div = {1'b0, {(SW-1){1'b1}}};
      end else begin
        held_div = $signed(div_q[SW-1:0]);
      end
    end
  end

  assign pc_w  = $signed(CW'(div_q));
  assign y_ext = CW'(y_q);
  always_comb begin
    if (y_ext > pc_w) begin
      clip_res = SW'(pc_w);
    end else if (y_ext < -pc_w) begin
      clip_res = SW'(-pc_w);
    end else begin
      clip_res = y_q;
    end
  end

  assign nx1 = noise_q ^ (noise_q << 13);
  assign nx2 = nx1 ^ (nx1 >> 17);
  assign nx3 = nx2 ^ (nx2 << 5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= SPACING_W'(1);
      noise_q   <= SEED_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SPACING: begin
          spacing_q <= cfg_data_i[SPACING_W-1:0];
        end
        REG_NOISE_SEED: begin
          noise_q <= cfg_data_i[31:0];
        end
        default: begin
        end
      endcase
    end else if (cmd_i.finish) begin
      noise_q <= nx3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      held_q <= '0;
      pos_q  <= 1'b0;
      neg_q  <= 1'b0;
    end else begin
      if (cmd_i.load_in) begin
        x_q <= in_sample_i;
      end else if (cmd_i.wr_x_blend) begin
        x_q <= blend_res;
      end
      if (cmd_i.wr_held_blend) begin
        held_q <= blend_res;
      end else if (cmd_i.wr_held_ceil) begin
        held_q <= ceil_res;
      end else if (cmd_i.wr_held_div) begin
        held_q <= held_div;
      end else if (cmd_i.shift) begin
        held_q <= dly_q[1];
      end
      if (cmd_i.pos_upd) begin
        pos_q <= (64'(x_q) > 64'sd952641);
      end
      if (cmd_i.neg_upd) begin
        neg_q <= (64'(x_q) < -64'sd952641);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_k || cmd_i.mul_blend || cmd_i.mul_slew) begin
      prod_q <= prod_w;
    end
    if (cmd_i.load_k) begin
      k_q <= prod_q[32+K_W-1:32];
    end
    if (cmd_i.shift) begin
      y_q <= held_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      max_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.shift) begin
      idx_q <= '0;
      max_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + 1'b1;
      if (slew_q[idx_q] > max_q) begin
        max_q <= slew_q[idx_q];
      end
      if (idx_q <= IW'(s_w)) begin
        sum_q <= sum_q + SUMW'(dly_q[idx_q[DIW-1:0]]);
      end
    end
  end

  for (genvar j = 0; j < WD; j++) begin : g_slew
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slew_q[j] <= '0;
      end else if (cmd_i.shift) begin
        if (IW'(j) == two_s_w) begin
          slew_q[j] <= slew_mag;
        end else if (IW'(j) < two_s_w) begin
          slew_q[j] <= slew_q[(j < WD - 1) ? j + 1 : j];
        end
      end
    end
  end

  for (genvar j = 0; j < DD; j++) begin : g_dly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dly_q[j] <= '0;
      end else if (cmd_i.shift) begin
        if (SPW'(j) == s_w) begin
          dly_q[j] <= x_q;
        end else if (SPW'(j) < s_w) begin
          dly_q[j] <= dly_q[(j < DD - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= clip_res;
    end
  end

  assign out_sample_o = out_q;
  assign out_valid_o  = out_valid_q;

  assign stat_o.pos_flag  = pos_q;
  assign stat_o.neg_flag  = neg_q;
  assign stat_o.x_gt_thr  = (64'(x_q) > 64'sd952641);
  assign stat_o.x_lt_nthr = (64'(x_q) < -64'sd952641);
  assign stat_o.x_lt_held = (x_q < held_q);
  assign stat_o.x_gt_held = (x_q > held_q);
  assign stat_o.scan_last = (idx_q == two_s_w);
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

endmodule
`default_nettype wire

[rtl/lsc_ctrl.sv]
`default_nettype none
module lsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lsc_pkg::lsc_stat_t stat_i,
  output lsc_pkg::lsc_cmd_t  cmd_o
);
  import lsc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KMUL, ST_KLOAD, ST_P1, ST_P1W, ST_P2, ST_P2W, ST_N1, ST_N1W,
    ST_N2, ST_N2W, ST_SHIFT, ST_SCAN, ST_MDIV, ST_MDIVW, ST_SMUL, ST_DSET,
    ST_PDIVW, ST_FIN
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_KMUL;
        end
      end
      ST_KMUL: begin
        cmd_o.mul_k = 1'b1;
        state_d     = ST_KLOAD;
      end
      ST_KLOAD: begin
        cmd_o.load_k = 1'b1;
        state_d      = ST_P1;
      end
      ST_P1: begin
        cmd_o.blend_b_x = 1'b1;
        if (stat_i.pos_flag && stat_i.x_lt_held) begin
          cmd_o.mul_blend = 1'b1;
          state_d         = ST_P1W;
        end else begin
          cmd_o.wr_held_ceil = stat_i.pos_flag;
          state_d            = ST_P2;
        end
      end
      ST_P1W: begin
        cmd_o.wr_held_blend = 1'b1;
        state_d             = ST_P2;
      end
      ST_P2: begin
        cmd_o.pos_upd = 1'b1;
        if (stat_i.x_gt_thr) begin
          cmd_o.mul_blend = 1'b1;
          state_d         = ST_P2W;
        end else begin
          state_d = ST_N1;
        end
      end
      ST_P2W: begin
        cmd_o.wr_x_blend = 1'b1;
        state_d          = ST_N1;
      end
      ST_N1: begin
        cmd_o.neg_side  = 1'b1;
        cmd_o.blend_b_x = 1'b1;
        if (stat_i.neg_flag && stat_i.x_gt_held) begin
          cmd_o.mul_blend = 1'b1;
          state_d         = ST_N1W;
        end else begin
          cmd_o.wr_held_ceil = stat_i.neg_flag;
          state_d            = ST_N2;
        end
      end
      ST_N1W: begin
        cmd_o.neg_side      = 1'b1;
        cmd_o.wr_held_blend = 1'b1;
        state_d             = ST_N2;
      end
      ST_N2: begin
        cmd_o.neg_side = 1'b1;
        cmd_o.neg_upd  = 1'b1;
        if (stat_i.x_lt_nthr) begin
          cmd_o.mul_blend = 1'b1;
          state_d         = ST_N2W;
        end else begin
          state_d = ST_SHIFT;
        end
      end
      ST_N2W: begin
        cmd_o.neg_side   = 1'b1;
        cmd_o.wr_x_blend = 1'b1;
        state_d          = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = (stat_i.pos_flag || stat_i.neg_flag) ? ST_MDIV : ST_SMUL;
        end
      end
      ST_MDIV: begin
        cmd_o.start_mag = 1'b1;
        state_d         = ST_MDIVW;
      end
      ST_MDIVW: begin
        if (!stat_i.div_busy) begin
          cmd_o.wr_held_div = 1'b1;
          state_d           = ST_SMUL;
        end
      end
      ST_SMUL: begin
        cmd_o.mul_slew = 1'b1;
        state_d        = ST_DSET;
      end
      ST_DSET: begin
        cmd_o.start_pc = 1'b1;
        state_d        = ST_PDIVW;
      end
      ST_PDIVW: begin
        if (!stat_i.div_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule
`default_nettype wire

[rtl/lookahead_soft_clipper.sv]
// Look-ahead soft clipper for one mono stream of signed Q3.20 samples.
// Input words arrive on in_i and clipped words leave on out_o; both use a
// valid/ready handshake and a word moves when both are high at a clock edge.
// The cfg port writes spacing (index 0) and the noise seed (index 1); it
// is to be used only while the block holds no word.
// One word is processed at a time. For each word the controller runs the
// noise multiply, the positive and negative clip checks with any blend
// writes, the delay-line shift, the window scan and the output ceiling
// divide; a word that clips runs the held-value divide before that. Both
// divides share one bit-serial divider, which sets most of a word's time.
// The result sits in an output register: the next word is accepted while
// it waits, and a finished word stalls in the controller until the output
// register is free. A stalled receiver therefore holds back at most one
// further word. Reset clears all history and loads the default seed.
`default_nettype none
module lookahead_soft_clipper #(
  parameter int unsigned MAX_SPACING  = lsc_pkg::MAX_SPACING_DEF,
  parameter int unsigned SAMPLE_WIDTH = lsc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lsc_in_if.sink                         in_i,
  lsc_out_if.source                      out_o
);
  import lsc_pkg::*;

  lsc_cmd_t  cmd;
  lsc_stat_t stat;

  lsc_ctrl u_lsc_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsc_datapath #(
    .MAX_SPACING  (MAX_SPACING),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_lsc_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (in_i.in_sample),
    .out_sample_o (out_o.out_sample),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
`default_nettype wire

[rtl/lsc_checker.sv]
`default_nettype none
module lsc_checker #(
  parameter int unsigned SAMPLE_WIDTH = lsc_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] out_sample_i
);
  import lsc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("output word dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while a word is in progress");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after acceptance");

  a_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_sample_i <= CEIL_Q) && (out_sample_i >= -CEIL_Q))
    else $error("output word beyond the clip ceiling");

endmodule

bind lookahead_soft_clipper lsc_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.out_sample)
);
`default_nettype wire

[bench/lookahead_soft_clipper_tb.sv]
`timescale 1ns / 100ps
module lookahead_soft_clipper_tb;
  import lsc_pkg::*;

  localparam int NDIR = 14;

  typedef struct {
    logic [23:0] sample;
    bit          known;
    logic [23:0] value;
  } clip_row_t;

  typedef struct {
    logic [23:0] value;
    bit          known;
    logic [23:0] typed;
  } clip_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = REG_SPACING;
  logic [31:0] cfg_data_i = '0;

  lsc_in_if  in_bus ();
  lsc_out_if out_bus ();

  lookahead_soft_clipper dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_bus), .out_o(out_bus)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [4:0]  spc_q;
  logic [31:0] noise_q;
  longint      held_q;
  bit          pos_q, neg_q;
  longint      dly_q [0:16];
  longint      slw_q [0:32];

  clip_exp_t   clip_expq [$];
  bit          cur_known = 0;
  logic [23:0] cur_typed = '0;
  bit          calm = 1;
  int          mismatches = 0;
  int          words_out = 0;
  int          clips_seen = 0;
  int          stall_left = 0;

  function automatic longint blend(longint a, longint b, longint k);
    return a + (((b - a) * k + (64'sd1 <<< 31)) >>> 32);
  endfunction

  function automatic logic [23:0] clip_word(logic signed [23:0] xin);
    longint s, x, k, d, sum, mag, pc, y, maxs;
    s = spc_q;
    if (s < 1) s = 1;
    if (s > 16) s = 16;
    x = xin;
    k = longint'((64'(noise_q) * 64'(NOISE_K_Q32)) >> 32);
    if (pos_q) held_q = (x < held_q) ? blend(THR_Q, x, k) : CEIL_Q;
    pos_q = 0;
    if (x > THR_Q) begin
      pos_q = 1;
      x = blend(THR_Q, held_q, k);
    end
    if (neg_q) held_q = (x > held_q) ? blend(-THR_Q, x, k) : -CEIL_Q;
    neg_q = 0;
    if (x < -THR_Q) begin
      neg_q = 1;
      x = blend(-THR_Q, held_q, k);
    end
    if (pos_q || neg_q) clips_seen++;
    d = held_q - x;
    for (int i = 0; i < 2 * s; i++) slw_q[i] = slw_q[i + 1];
    slw_q[2 * s] = (d < 0) ? -d : d;
    for (int i = 0; i < s; i++) dly_q[i] = dly_q[i + 1];
    dly_q[s] = x;
    y = held_q;
    held_q = dly_q[0];
    if (pos_q || neg_q) begin
      sum = 0;
      for (int i = 0; i <= s; i++) sum += dly_q[i];
      mag = (((sum < 0) ? -sum : sum) + s / 2) / s;
      held_q = (sum < 0) ? -mag : mag;
      if (held_q > 8388607) held_q = 8388607;
      if (held_q < -8388608) held_q = -8388608;
    end
    maxs = 0;
    for (int i = 0; i <= 2 * s; i++) if (slw_q[i] > maxs) maxs = slw_q[i];
    d = 1048576 + ((maxs * SLEW_K_Q + 524288) >> 20);
    pc = (longint'(CEIL_Q40) + d / 2) / d;
    if (y > pc) y = pc;
    if (y < -pc) y = -pc;
    noise_q ^= noise_q << 13;
    noise_q ^= noise_q >> 17;
    noise_q ^= noise_q << 5;
    return y[23:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    clip_exp_t e;
    if (!rst_ni) begin
      spc_q = 1;
      noise_q = SEED_RESET;
      held_q = 0;
      pos_q = 0;
      neg_q = 0;
      foreach (dly_q[i]) dly_q[i] = 0;
      foreach (slw_q[i]) slw_q[i] = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SPACING) spc_q = cfg_data_i[4:0];
        else noise_q = cfg_data_i;
      end
      if (in_bus.valid && in_bus.ready) begin
        e.value = clip_word(in_bus.in_sample);
        e.known = cur_known;
        e.typed = cur_typed;
        clip_expq.push_back(e);
      end
      if (out_bus.valid && out_bus.ready) begin
        words_out++;
        if (clip_expq.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_bus.out_sample);
        end else begin
          e = clip_expq.pop_front();
          if (e.known) e.value = e.typed;
          if (out_bus.out_sample !== e.value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_sample mismatch: expected %h, got %h", e.value,
                       out_bus.out_sample);
          end
        end
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left--;
    end else begin
      out_bus.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) stall_left = gap_len();
    end
  end

  task automatic send(logic [23:0] smp, bit known, logic [23:0] typed);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.in_sample <= smp;
    cur_known = known;
    cur_typed = typed;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    cur_known = 0;
    while (clip_expq.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [23:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      r = $urandom_range(850000, 1200000);
      return ($urandom_range(0, 1) != 0) ? 24'(r) : 24'(-r);
    end
    if (r < 75) return 24'($urandom);
    return 24'($signed($urandom_range(0, 400000)) - 200000);
  endfunction

  clip_row_t dir_rows [NDIR] = '{
    '{24'd0, 1, 24'd0},
    '{24'h7FFFFF, 0, 24'd0},
    '{24'h800000, 0, 24'd0},
    '{24'(952641), 0, 24'd0},
    '{24'(952642), 0, 24'd0},
    '{24'(952642), 0, 24'd0},
    '{24'(-952641), 0, 24'd0},
    '{24'(-952642), 0, 24'd0},
    '{24'(-952642), 0, 24'd0},
    '{24'(100), 0, 24'd0},
    '{24'h7FFFFF, 0, 24'd0},
    '{24'(-8000), 0, 24'd0},
    '{24'h555555, 0, 24'd0},
    '{24'hAAAAAA, 0, 24'd0}
  };

  logic [4:0]  spc_set  [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd2};
  logic [31:0] seed_set [6] = '{32'd16386, 32'hFFFFFFFF, 32'd0, 32'h9E3779B9,
                                32'hDEADBEEF, SEED_RESET};

  initial begin
    in_bus.valid = 1'b0;
    in_bus.in_sample = '0;
    out_bus.ready = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    foreach (dir_rows[i]) send(dir_rows[i].sample, dir_rows[i].known, dir_rows[i].value);
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_SPACING, 32'(spc_set[p]));
      write_reg(REG_NOISE_SEED, seed_set[p]);
      calm = (p == 1);
      for (int n = 0; n < 208; n++) send(rand_sample(), 0, '0);
    end
    in_bus.valid <= 1'b0;
    while (clip_expq.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    $display("%0d words checked, %0d of them clipped, over six spacing/seed settings",
             words_out, clips_seen);
    if (mismatches == 0 && clip_expq.size() == 0) begin
      $display("[lookahead_soft_clipper] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[lookahead_soft_clipper] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timed out with %0d words outstanding", clip_expq.size());
    $display("[lookahead_soft_clipper] ERROR");
    $finish;
  end

endmodule
